FILE: rtl/pose_transform_2d_top_macros.svh
`ifndef POSE_TRANSFORM_2D_TOP_MACROS_SVH
`define POSE_TRANSFORM_2D_TOP_MACROS_SVH

// clocked assertion, off while in reset
`define PT2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define PT2_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pt2_pkg.sv
package pt2_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int RW = 24;
  localparam int ZW = 33;
  localparam int VW = 44;

  localparam logic [2:0] REG_LIN_A   = 3'd0;
  localparam logic [2:0] REG_LIN_B   = 3'd1;
  localparam logic [2:0] REG_LIN_C   = 3'd2;
  localparam logic [2:0] REG_LIN_D   = 3'd3;
  localparam logic [2:0] REG_SHIFT_X = 3'd4;
  localparam logic [2:0] REG_SHIFT_Y = 3'd5;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [15:0] lin_a;
    logic signed [15:0] lin_b;
    logic signed [15:0] lin_c;
    logic signed [15:0] lin_d;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic signed [23:0]   px;
    logic signed [23:0]   py;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic signed [23:0]   ox;
    logic signed [23:0]   oy;
    logic                 clip;
  } vec_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [23:0] oy;
    logic signed [23:0] ox;
    logic               clip;
  } res_t;

endpackage

FILE: rtl/pose_transform_2d_top.sv
// Pipeline from the input transfer to out_tvalid: rotation cells, three
// product/sum/result stages, vectoring cells, one output register.
// Throughput: one pose per cycle while the skid stage is empty (in_tready high);
// a two-entry output register and skid stage hold results while out_tready is low.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity.
module pose_transform_2d_top import pt2_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos_x[23:0], pos_y[47:24], heading[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_x[23:0], out_y[47:24], out_heading[63:48]
  output logic [0:0]  out_tuser,  // clipped[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = CORDIC_STAGES;

  cfg_t cfg_r;

  logic en;
  logic rot_v [N+1];
  rot_t rot_d [N+1];
  logic vec_v [N+1];
  vec_t vec_d [N+1];

  logic signed [15:0]   in_h;
  logic signed [ZW-1:0] z0;

  res_t last_d;
  res_t out_d_r, skid_d_r;
  logic out_v_r, skid_v_r;
  logic [31:0] hz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lin_a   <= 16'sd16384;
      cfg_r.lin_b   <= '0;
      cfg_r.lin_c   <= '0;
      cfg_r.lin_d   <= 16'sd16384;
      cfg_r.shift_x <= '0;
      cfg_r.shift_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIN_A:   cfg_r.lin_a   <= cfg_data[15:0];
        REG_LIN_B:   cfg_r.lin_b   <= cfg_data[15:0];
        REG_LIN_C:   cfg_r.lin_c   <= cfg_data[15:0];
        REG_LIN_D:   cfg_r.lin_d   <= cfg_data[15:0];
        REG_SHIFT_X: cfg_r.shift_x <= cfg_data;
        REG_SHIFT_Y: cfg_r.shift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign in_h      = in_tdata[63:48];

  always_comb begin
    z0 = $signed({in_h[15], in_h, 16'b0});
    rot_d[0].flip = 1'b0;
    if (in_h > 16'sd16384) begin
      z0 = z0 - 33'sh080000000;
      rot_d[0].flip = 1'b1;
    end else if (in_h < -16'sd16384) begin
      z0 = z0 + 33'sh080000000;
      rot_d[0].flip = 1'b1;
    end
    rot_d[0].x  = 24'sd1048576;
    rot_d[0].y  = '0;
    rot_d[0].z  = z0;
    rot_d[0].px = in_tdata[23:0];
    rot_d[0].py = in_tdata[47:24];
  end

  assign rot_v[0] = in_tvalid;

  for (genvar i = 0; i < N; i++) begin : g_rot
    pt2_rot_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(rot_v[i]), .d_i(rot_d[i]), .v_o(rot_v[i+1]), .d_o(rot_d[i+1])
    );
  end

  pt2_mix u_mix (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .v_i(rot_v[N]), .d_i(rot_d[N]), .v_o(vec_v[0]), .d_o(vec_d[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_vec
    pt2_vec_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(vec_v[i]), .d_i(vec_d[i]), .v_o(vec_v[i+1]), .d_o(vec_d[i+1])
    );
  end

  assign hz = vec_d[N].z[31:0] + 32'h0000_8000;

  always_comb begin
    last_d.ox      = vec_d[N].ox;
    last_d.oy      = vec_d[N].oy;
    last_d.clip    = vec_d[N].clip;
    last_d.heading = vec_d[N].zero ? 16'd0 : hz[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (vec_v[N]) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (vec_v[N]) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= last_d;
      end else begin
        out_d_r <= last_d;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_d_r.heading, out_d_r.oy, out_d_r.ox};
  assign out_tuser  = out_d_r.clip;

endmodule

FILE: rtl/pt2_rot_cell.sv
module pt2_rot_cell import pt2_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic v_i,
  input  rot_t d_i,
  output logic v_o,
  output rot_t d_o
);

  localparam logic signed [ZW-1:0] ANG = $signed({1'b0, ATAN_TAB[IDX]});

  logic v_r;
  rot_t d_r, d_nxt;

  always_comb begin
    d_nxt = d_i;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - (d_i.y >>> IDX);
      d_nxt.y = d_i.y + (d_i.x >>> IDX);
      d_nxt.z = d_i.z - ANG;
    end else begin
      d_nxt.x = d_i.x + (d_i.y >>> IDX);
      d_nxt.y = d_i.y - (d_i.x >>> IDX);
      d_nxt.z = d_i.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

FILE: rtl/pt2_vec_cell.sv
module pt2_vec_cell import pt2_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic v_i,
  input  vec_t d_i,
  output logic v_o,
  output vec_t d_o
);

  localparam logic signed [ZW-1:0] ANG = $signed({1'b0, ATAN_TAB[IDX]});

  logic v_r;
  vec_t d_r, d_nxt;

  always_comb begin
    d_nxt = d_i;
    if (d_i.y > 0) begin
      d_nxt.x = d_i.x + (d_i.y >>> IDX);
      d_nxt.y = d_i.y - (d_i.x >>> IDX);
      d_nxt.z = d_i.z + ANG;
    end else begin
      d_nxt.x = d_i.x - (d_i.y >>> IDX);
      d_nxt.y = d_i.y + (d_i.x >>> IDX);
      d_nxt.z = d_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

FILE: rtl/pt2_mix.sv
module pt2_mix import pt2_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  cfg_t cfg,
  input  logic v_i,
  input  rot_t d_i,
  output logic v_o,
  output vec_t d_o
);

  localparam logic signed [41:0] POS_MAX = 42'sd8388607;
  localparam logic signed [41:0] POS_MIN = -42'sd8388608;
  localparam logic signed [ZW-1:0] ANG_PI = 33'sh080000000;

  logic signed [RW-1:0] cos_v, sin_v;

  // product stage
  logic               p_v_r;
  logic signed [39:0] p_ax_r, p_by_r, p_cx_r, p_dy_r;
  logic signed [39:0] p_ac_r, p_bs_r, p_bc_r, p_as_r;

  // sum stage
  logic               s_v_r;
  logic signed [41:0] s_x_r, s_y_r;
  logic signed [40:0] s_m00_r, s_my_r;
  logic signed [41:0] tx_ext, ty_ext;

  // result stage
  logic               r_v_r;
  vec_t               r_d_r, r_d_nxt;
  logic signed [41:0] qx, qy;
  logic               clip_x, clip_y;

  assign cos_v = d_i.flip ? -d_i.x : d_i.x;
  assign sin_v = d_i.flip ? -d_i.y : d_i.y;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ax_r <= cfg.lin_a * d_i.px;
      p_by_r <= cfg.lin_b * d_i.py;
      p_cx_r <= cfg.lin_c * d_i.px;
      p_dy_r <= cfg.lin_d * d_i.py;
      p_ac_r <= cfg.lin_a * cos_v;
      p_bs_r <= cfg.lin_b * sin_v;
      p_bc_r <= cfg.lin_b * cos_v;
      p_as_r <= cfg.lin_a * sin_v;
    end
  end

  assign tx_ext = $signed({{4{cfg.shift_x[31]}}, cfg.shift_x, 6'b0});
  assign ty_ext = $signed({{4{cfg.shift_y[31]}}, cfg.shift_y, 6'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      s_x_r   <= p_ax_r + p_by_r + tx_ext;
      s_y_r   <= p_cx_r + p_dy_r + ty_ext;
      s_m00_r <= p_ac_r + p_bs_r;
      s_my_r  <= p_as_r - p_bc_r;
    end
  end

  always_comb begin
    qx = (s_x_r + $signed({28'd0, {14{s_x_r[41]}}})) >>> 14;
    qy = (s_y_r + $signed({28'd0, {14{s_y_r[41]}}})) >>> 14;
    clip_x = (qx > POS_MAX) || (qx < POS_MIN);
    clip_y = (qy > POS_MAX) || (qy < POS_MIN);
    r_d_nxt.ox = (qx > POS_MAX) ? 24'sh7fffff :
                 (qx < POS_MIN) ? 24'sh800000 : qx[23:0];
    r_d_nxt.oy = (qy > POS_MAX) ? 24'sh7fffff :
                 (qy < POS_MIN) ? 24'sh800000 : qy[23:0];
    r_d_nxt.clip = clip_x || clip_y;
    r_d_nxt.zero = (s_m00_r == 0) && (s_my_r == 0);
    if (s_m00_r < 0) begin
      r_d_nxt.x = -VW'(s_m00_r);
      r_d_nxt.y = -VW'(s_my_r);
      r_d_nxt.z = ANG_PI;
    end else begin
      r_d_nxt.x = VW'(s_m00_r);
      r_d_nxt.y = VW'(s_my_r);
      r_d_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_d_r <= r_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      r_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= v_i;
      s_v_r <= p_v_r;
      r_v_r <= s_v_r;
    end
  end

  assign v_o = r_v_r;
  assign d_o = r_d_r;

endmodule

FILE: rtl/pt2_checker.sv
`include "pose_transform_2d_top_macros.svh"

module pt2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  `PT2_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped")
  `PT2_ASSERT(a_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled data moved")
  `PT2_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result after reset")
  `PT2_ASSERT(a_clip_rail, out_tvalid && out_tuser[0] |-> out_tdata[23:0] == 24'h7fffff || out_tdata[23:0] == 24'h800000 || out_tdata[47:24] == 24'h7fffff || out_tdata[47:24] == 24'h800000, "clipped without saturated position")
  `PT2_ASSERT(a_stall_in, !in_tready |-> out_tvalid, "input stalled while output empty")

endmodule

bind pose_transform_2d_top pt2_checker u_pt2_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);

FILE: bench/pose_transform_2d_checker.sv
`timescale 1ns / 100ps
module pose_transform_2d_checker import pt2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] hd;
    logic        clip;
  } pose_res_t;

  localparam int NSTG = (CORDIC_STAGES_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES_DEF;

  longint m_a, m_b, m_c, m_d, t_x, t_y;
  pose_res_t pose_q[$];

  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint map_axis(longint m0, longint m1, longint t, longint x, longint y,
                                      ref bit clip);
    longint s, q;
    s = m0 * x + m1 * y + t * 64;
    q = s / 16384;
    if (q > 8388607) begin
      clip = 1;
      return 8388607;
    end
    if (q < -8388608) begin
      clip = 1;
      return -8388608;
    end
    return q;
  endfunction

  function automatic pose_res_t transform_pose(logic [63:0] d);
    pose_res_t r;
    longint x, y, h, z, cx, sy, nx, m00, m01, vx, vy, vz;
    bit clip, flip;
    logic [31:0] u;
    x = longint'($signed(d[23:0]));
    y = longint'($signed(d[47:24]));
    h = longint'($signed(d[63:48]));
    clip = 0;
    r.px = 24'(map_axis(m_a, m_b, t_x, x, y, clip));
    r.py = 24'(map_axis(m_c, m_d, t_y, x, y, clip));
    r.clip = clip;
    z = h * 65536;
    cx = 64'sd1 << 20;
    sy = 0;
    flip = 0;
    if (h > 16384) begin
      z -= 64'sd1 << 31;
      flip = 1;
    end else if (h < -16384) begin
      z += 64'sd1 << 31;
      flip = 1;
    end
    for (int i = 0; i < NSTG; i++) begin
      if (z >= 0) begin
        nx = cx - sra(sy, i); sy = sy + sra(cx, i); z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = cx + sra(sy, i); sy = sy - sra(cx, i); z += longint'(ATAN_TAB[i]);
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    m00 = m_a * cx + m_b * sy;
    m01 = m_b * cx - m_a * sy;
    vx = m00;
    vy = -m01;
    vz = 0;
    if (vx == 0 && vy == 0) begin
      r.hd = 16'd0;
    end else begin
      if (vx < 0) begin
        vx = -vx; vy = -vy; vz = 64'sd1 << 31;
      end
      for (int i = 0; i < NSTG; i++) begin
        if (vy > 0) begin
          nx = vx + sra(vy, i); vy = vy - sra(vx, i); vz += longint'(ATAN_TAB[i]);
        end else begin
          nx = vx - sra(vy, i); vy = vy + sra(vx, i); vz -= longint'(ATAN_TAB[i]);
        end
        vx = nx;
      end
      u = vz[31:0] + 32'h8000;
      r.hd = u[31:16];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pose_res_t e;
    if (!rst_n) begin
      m_a = 16384; m_b = 0; m_c = 0; m_d = 16384; t_x = 0; t_y = 0;
      pose_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) pose_q.push_back(transform_pose(in_tdata));
      if (out_tvalid && out_tready) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          if (out_tdata[23:0] !== e.px || out_tdata[47:24] !== e.py ||
              out_tdata[63:48] !== e.hd || out_tuser[0] !== e.clip) begin
            $display("%0t: mismatch exp x=%h y=%h h=%h c=%b got x=%h y=%h h=%h c=%b",
                     $time, e.px, e.py, e.hd, e.clip, out_tdata[23:0],
                     out_tdata[47:24], out_tdata[63:48], out_tuser[0]);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LIN_A:   m_a = longint'($signed(cfg_data[15:0]));
          REG_LIN_B:   m_b = longint'($signed(cfg_data[15:0]));
          REG_LIN_C:   m_c = longint'($signed(cfg_data[15:0]));
          REG_LIN_D:   m_d = longint'($signed(cfg_data[15:0]));
          REG_SHIFT_X: t_x = longint'($signed(cfg_data));
          REG_SHIFT_Y: t_y = longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
    pending = pose_q.size();
  end
endmodule

FILE: bench/tb_pose_transform_2d_top.sv
`timescale 1ns / 100ps
module tb_pose_transform_2d_top;
  import pt2_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          hold_off = 0;
  bit          sent_all = 0;

  pose_transform_2d_top dut (.*);

  pose_transform_2d_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_pose_transform_2d_top: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 3) == 0) w = 0;
      else w = $urandom_range(0, 6);
      if (sent_all) w = 0;
      if (w == 0) out_tready <= 1;
      else begin
        out_tready <= 0;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
        out_tready <= 1;
      end
    end
  end

  task automatic send_pose(logic [23:0] x, logic [23:0] y, logic [15:0] h, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 6) : 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(negedge clk);
    end
    in_tdata <= {h, y, x};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [23:0] rand_pos(int mode);
    case (mode)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 2000)) - 24'd1000;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    bit gaps;
    logic [15:0] hd [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                             16'h4001, 16'hBFFF, 16'h2000, 16'hE000, 16'h0001,
                             16'hFFFF, 16'h6000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (hd[i]) send_pose(rand_pos(i % 4), rand_pos((i + 1) % 4), hd[i], 1);
    send_pose(24'h7FFFFF, 24'h7FFFFF, 16'h1234, 0);
    send_pose(24'h800000, 24'h800000, 16'h8765, 0);
    drain();
    write_reg(REG_LIN_A, 32'h0000_7FFF);
    write_reg(REG_LIN_B, 32'h0000_8000);
    write_reg(REG_LIN_C, 32'h0000_8000);
    write_reg(REG_LIN_D, 32'h0000_7FFF);
    write_reg(REG_SHIFT_X, 32'h7FFF_FFFF);
    write_reg(REG_SHIFT_Y, 32'h8000_0000);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_pose(rand_pos(i % 4), rand_pos(3 - i % 4), hd[i], 0);
    drain();
    write_reg(REG_LIN_A, 32'h0);
    write_reg(REG_LIN_B, 32'h0);
    for (int i = 0; i < 4; i++) send_pose(rand_pos(3), rand_pos(3), hd[i], 0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 6; r++) begin
        if (ph == 7) write_reg(r[2:0], (r < 4) ? ((r == 0 || r == 3) ? 32'h4000 : 32'h0) : 32'h0);
        else if ($urandom_range(0, 3) == 0)
          write_reg(r[2:0], (r < 4) ? (($urandom_range(0, 1)) ? 32'h8000 : 32'h7FFF)
                                     : (($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF));
        else write_reg(r[2:0], $urandom);
      end
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 80; n++) begin
        gaps = (ph % 3 != 1);
        send_pose(rand_pos($urandom_range(0, 5)), rand_pos($urandom_range(0, 5)),
                  16'($urandom), gaps);
        if (ph == 4 && n == 40) begin
          in_tvalid <= 0;
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end
    sent_all = 1;
    drain();
    if (fail_count == 0) $display("tb_pose_transform_2d_top: done, clean");
    else $display("tb_pose_transform_2d_top: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/pt2_pkg.sv
rtl/pt2_rot_cell.sv
rtl/pt2_vec_cell.sv
rtl/pt2_mix.sv
rtl/pose_transform_2d_top.sv
rtl/pt2_checker.sv
bench/pose_transform_2d_checker.sv
bench/tb_pose_transform_2d_top.sv
